// ===== rtl/positional_list_editor_macros.svh =====
// Assertion macros for the positional list editor checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POSITIONAL_LIST_EDITOR_MACROS_SVH
`define POSITIONAL_LIST_EDITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("positional list editor: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("positional list editor: next-cycle check failed");

`endif

// ===== rtl/ple_pkg.sv =====
// Shared constants, codes and structs of the positional list editor.
// No dependencies; imported by every module of the block.
package ple_pkg;

  localparam int CAPACITY = 8192;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 14;
  localparam int WORD_W   = 20;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  // Command opcodes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Access bundle from the sequencer to the word and link memories
  typedef struct packed {
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [SLOT_W-1:0] link_wdata;
    logic [SLOT_W-1:0] link_raddr;
    logic              word_we;
    logic [SLOT_W-1:0] word_waddr;
    logic [WORD_W-1:0] word_wdata;
    logic [SLOT_W-1:0] word_raddr;
  } store_req_t;

  // One result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_value;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

// ===== rtl/ple_store.sv =====
// Word and link memories of the list, one write and one registered read each.
// Depends on ple_pkg.
module ple_store (
  input  logic                      clk_i,
  input  ple_pkg::store_req_t       req_i,
  output logic [ple_pkg::SLOT_W-1:0] link_rdata_o,
  output logic [ple_pkg::WORD_W-1:0] word_rdata_o
);
  import ple_pkg::*;

  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [WORD_W-1:0] word_mem [CAPACITY];

  // Link memory: write then registered read
  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    link_rdata_o <= link_mem[req_i.link_raddr];
  end

  // Word memory: write then registered read
  always_ff @(posedge clk_i) begin
    if (req_i.word_we) begin
      word_mem[req_i.word_waddr] <= req_i.word_wdata;
    end
    word_rdata_o <= word_mem[req_i.word_raddr];
  end

endmodule

// ===== rtl/ple_ctrl.sv =====
// Command sequencer with the shared link walker of the positional list editor.
// Depends on ple_pkg; drives the memories in ple_store.
module ple_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ple_pkg::OP_W-1:0]   opcode_i,
  input  logic [ple_pkg::LEN_W-1:0]  position_i,
  input  logic [ple_pkg::LEN_W-1:0]  count_i,
  input  logic [ple_pkg::WORD_W-1:0] value_i,
  output logic                       idle_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ple_pkg::result_t           res_o,
  output ple_pkg::store_req_t        store_o,
  input  logic [ple_pkg::SLOT_W-1:0] link_rdata_i,
  input  logic [ple_pkg::WORD_W-1:0] word_rdata_i
);
  import ple_pkg::*;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_CHECK  = 4'd1;
  localparam logic [STATE_W-1:0] S_TAKE   = 4'd2;
  localparam logic [STATE_W-1:0] S_PLACE  = 4'd3;
  localparam logic [STATE_W-1:0] S_DSTART = 4'd4;
  localparam logic [STATE_W-1:0] S_WALK   = 4'd5;
  localparam logic [STATE_W-1:0] S_HOP    = 4'd6;
  localparam logic [STATE_W-1:0] S_INS_A  = 4'd7;
  localparam logic [STATE_W-1:0] S_INS_B  = 4'd8;
  localparam logic [STATE_W-1:0] S_DEL_A  = 4'd9;
  localparam logic [STATE_W-1:0] S_DEL_B  = 4'd10;
  localparam logic [STATE_W-1:0] S_RD_A   = 4'd11;
  localparam logic [STATE_W-1:0] S_RD_B   = 4'd12;
  localparam logic [STATE_W-1:0] S_FINISH = 4'd13;

  // Control state
  logic [STATE_W-1:0] state_q, state_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [SLOT_W-1:0]  tail_q, tail_d;
  logic [SLOT_W-1:0]  free_q, free_d;
  logic [LEN_W-1:0]   fresh_q, fresh_d;
  logic [LEN_W-1:0]   len_q, len_d;

  // Command and walker registers
  logic [STATE_W-1:0] ret_q, ret_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [WORD_W-1:0]  val_q, val_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [WORD_W-1:0]  rd_q, rd_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  cur_q, cur_d;
  logic [SLOT_W-1:0]  prv_q, prv_d;
  logic [SLOT_W-1:0]  pre_q, pre_d;
  logic [SLOT_W-1:0]  first_q, first_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0]   tgt_q, tgt_d;
  logic               clip_q, clip_d;

  logic [LEN_W-1:0]   idx_inc;
  logic [LEN_W-1:0]   rem;

  assign idx_inc = idx_q + LEN_W'(1);
  assign rem     = len_q - pos_q;

  // Sequence one command: check, take a slot, walk links, relink or read a word
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    len_d    = len_q;
    ret_d    = ret_q;
    op_d     = op_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    status_d = status_q;
    rd_d     = rd_q;
    slot_d   = slot_q;
    cur_d    = cur_q;
    prv_d    = prv_q;
    pre_d    = pre_q;
    first_d  = first_q;
    idx_d    = idx_q;
    tgt_d    = tgt_q;
    clip_d   = clip_q;

    store_o            = '0;
    store_o.link_raddr = cur_q;
    store_o.word_raddr = cur_q;
    store_o.word_waddr = slot_q;
    store_o.word_wdata = val_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = opcode_i;
          pos_d    = (opcode_i == OP_APPEND) ? len_q : position_i;
          cnt_d    = count_i;
          val_d    = value_i;
          status_d = ST_OK;
          rd_d     = '0;
          state_d  = S_CHECK;
        end
      end

      S_CHECK: begin
        // Prefetch the link of the free chain head
        store_o.link_raddr = free_q;
        case (op_q)
          OP_APPEND, OP_INSERT: begin
            if (pos_q > len_q) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else if (fresh_q > len_q) begin
              slot_d  = free_q;
              state_d = S_TAKE;
            end else if (fresh_q < CAP_LEN) begin
              slot_d  = fresh_q[SLOT_W-1:0];
              fresh_d = fresh_q + LEN_W'(1);
              state_d = S_PLACE;
            end else begin
              status_d = ST_FULL;
              state_d  = S_FINISH;
            end
          end
          OP_DELETE: begin
            if (len_q == '0) begin
              state_d = S_FINISH;
            end else if (pos_q > len_q) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else begin
              // Clip the count at the end of the sequence
              if (cnt_q < rem) begin
                clip_d = 1'b0;
              end else begin
                cnt_d  = rem;
                clip_d = 1'b1;
              end
              state_d = S_DSTART;
            end
          end
          default: begin
            if (pos_q >= len_q) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else begin
              cur_d   = head_q;
              idx_d   = '0;
              tgt_d   = pos_q;
              ret_d   = S_RD_A;
              state_d = S_WALK;
            end
          end
        endcase
      end

      S_TAKE: begin
        // Pop the free chain
        free_d  = link_rdata_i;
        state_d = S_PLACE;
      end

      S_PLACE: begin
        store_o.word_we = 1'b1;
        if (len_q == '0) begin
          head_d  = slot_q;
          tail_d  = slot_q;
          len_d   = len_q + LEN_W'(1);
          state_d = S_FINISH;
        end else if (pos_q == '0) begin
          store_o.link_we    = 1'b1;
          store_o.link_waddr = slot_q;
          store_o.link_wdata = head_q;
          head_d             = slot_q;
          len_d              = len_q + LEN_W'(1);
          state_d            = S_FINISH;
        end else if (pos_q == len_q) begin
          store_o.link_we    = 1'b1;
          store_o.link_waddr = tail_q;
          store_o.link_wdata = slot_q;
          tail_d             = slot_q;
          len_d              = len_q + LEN_W'(1);
          state_d            = S_FINISH;
        end else begin
          cur_d   = head_q;
          idx_d   = '0;
          tgt_d   = pos_q;
          ret_d   = S_INS_A;
          state_d = S_WALK;
        end
      end

      S_DSTART: begin
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end else begin
          // Walk to the word just after the removed run
          cur_d   = head_q;
          first_d = head_q;
          idx_d   = '0;
          tgt_d   = pos_q + cnt_q;
          ret_d   = S_DEL_A;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        // Issue the first link read unless no hop is needed
        if (idx_q == tgt_q) begin
          state_d = ret_q;
        end else begin
          state_d = S_HOP;
        end
      end

      S_HOP: begin
        // Advance one link per cycle; read data feeds the next address
        prv_d = cur_q;
        cur_d = link_rdata_i;
        idx_d = idx_inc;
        if (idx_inc == pos_q) begin
          first_d = link_rdata_i;
          pre_d   = cur_q;
        end
        if (idx_inc == tgt_q) begin
          state_d = ret_q;
        end else begin
          store_o.link_raddr = link_rdata_i;
        end
      end

      S_INS_A: begin
        store_o.link_we    = 1'b1;
        store_o.link_waddr = slot_q;
        store_o.link_wdata = cur_q;
        state_d            = S_INS_B;
      end

      S_INS_B: begin
        store_o.link_we    = 1'b1;
        store_o.link_waddr = prv_q;
        store_o.link_wdata = slot_q;
        len_d              = len_q + LEN_W'(1);
        state_d            = S_FINISH;
      end

      S_DEL_A: begin
        // Bridge over the removed run
        if (pos_q == '0) begin
          head_d = cur_q;
        end else begin
          store_o.link_we    = 1'b1;
          store_o.link_waddr = pre_q;
          store_o.link_wdata = cur_q;
        end
        if (clip_q) begin
          tail_d = pre_q;
        end
        state_d = S_DEL_B;
      end

      S_DEL_B: begin
        // Push the removed run onto the free chain
        store_o.link_we    = 1'b1;
        store_o.link_waddr = prv_q;
        store_o.link_wdata = free_q;
        free_d             = first_q;
        len_d              = len_q - cnt_q;
        if (clip_q && (pos_q == '0)) begin
          head_d = '0;
          tail_d = '0;
        end
        state_d = S_FINISH;
      end

      S_RD_A: begin
        state_d = S_RD_B;
      end

      S_RD_B: begin
        rd_d    = word_rdata_i;
        state_d = S_FINISH;
      end

      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Clear control state on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      fresh_q <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      len_q   <= len_d;
    end
  end

  // Command and walker payload
  always_ff @(posedge clk_i) begin
    ret_q    <= ret_d;
    op_q     <= op_d;
    pos_q    <= pos_d;
    cnt_q    <= cnt_d;
    val_q    <= val_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    slot_q   <= slot_d;
    cur_q    <= cur_d;
    prv_q    <= prv_d;
    pre_q    <= pre_d;
    first_q  <= first_d;
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    clip_q   <= clip_d;
  end

  assign idle_o            = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_FINISH);
  assign res_o.status      = status_q;
  assign res_o.read_value  = rd_q;
  assign res_o.length      = len_q;

endmodule

// ===== rtl/positional_list_editor.sv =====
// Top level of the positional list editor: handshakes and the result register.
// Depends on ple_pkg, ple_store and ple_ctrl.
//
//   channel  direction  handshake              beat contents
//   in       to block   in_valid_i/in_stall_o  opcode_i position_i count_i value_i
//   out      from block out_valid_o/out_stall_i status_o read_value_o length_o
//
// One command at a time; in_stall_o stays high from the accepted beat until the
// result is loaded into the output register. The link walker follows one link a
// cycle through the link memory read port. Reset clears the list pointers and
// counts only; the memories need no clearing pass. A stalled result waits in the
// output register while the next command is taken.
module positional_list_editor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ple_pkg::OP_W-1:0]   opcode_i,
  input  logic [ple_pkg::LEN_W-1:0]  position_i,
  input  logic [ple_pkg::LEN_W-1:0]  count_i,
  input  logic [ple_pkg::WORD_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ple_pkg::STAT_W-1:0] status_o,
  output logic [ple_pkg::WORD_W-1:0] read_value_o,
  output logic [ple_pkg::LEN_W-1:0]  length_o
);
  import ple_pkg::*;

  logic              idle;
  logic              start;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_q;
  logic              out_valid_q;
  store_req_t        store_req;
  logic [SLOT_W-1:0] link_rdata;
  logic [WORD_W-1:0] word_rdata;

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;
  assign res_ready  = !out_valid_q || !out_stall_i;

  ple_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .count_i      (count_i),
    .value_i      (value_i),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .store_o      (store_req),
    .link_rdata_i (link_rdata),
    .word_rdata_i (word_rdata)
  );

  ple_store u_store (
    .clk_i        (clk_i),
    .req_i        (store_req),
    .link_rdata_o (link_rdata),
    .word_rdata_o (word_rdata)
  );

  // Track the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result when the register is free
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign read_value_o = out_q.read_value;
  assign length_o     = out_q.length;

endmodule

// ===== rtl/ple_checker.sv =====
// Port-level checks of the positional list editor, bound to the top level.
// Depends on ple_pkg and positional_list_editor_macros.svh.
`include "positional_list_editor_macros.svh"

module ple_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [ple_pkg::STAT_W-1:0] status_o,
  input logic [ple_pkg::WORD_W-1:0] read_value_o,
  input logic [ple_pkg::LEN_W-1:0]  length_o
);
  import ple_pkg::*;

  logic [STAT_W+WORD_W+LEN_W-1:0] out_beat;

  // Gather the result beat fields
  assign out_beat = {status_o, read_value_o, length_o};

  // Stalled result beat holds
  `PLE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat))

  // Accepted command keeps the block busy
  `PLE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Failed commands carry no read word
  `PLE_ASSERT_IMPLY(a_fail_no_word, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), read_value_o == '0)

  // Length never exceeds the capacity
  `PLE_ASSERT_IMPLY(a_len_cap, clk_i, rst_ni, out_valid_o, length_o <= CAP_LEN)

  // A full refusal only happens at capacity
  `PLE_ASSERT_IMPLY(a_full_at_cap, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL), length_o == CAP_LEN)

endmodule

bind positional_list_editor ple_checker u_ple_checker (.*);
